/* rtl/hhd_pkg.sv */
// Shared types and constants of the heading-hold drive controller.
`default_nettype none

package hhd_pkg;

    // Field widths.
    localparam int HEADING_W = 15;
    localparam int COUNT_W   = 16;
    localparam int CIRC_W    = 16;
    localparam int TARGET_W  = 26;
    localparam int PULSE_W   = 11;
    localparam int ERR_W     = 16;
    localparam int SPEED_W   = 8;
    localparam int PROD_W    = CIRC_W + COUNT_W;
    localparam int TRAVEL_W  = PROD_W + 1;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = TARGET_W;
    localparam logic [CFG_ADDR_W-1:0] CFG_LEFT_CIRC  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RIGHT_CIRC = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET     = 2'd2;
    localparam logic [CIRC_W-1:0]     CIRC_RESET     = 16'd5120;

    // Input item kinds.
    localparam logic MODE_START  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // Heading error wrap limits, in 1/64 degree.
    localparam logic signed [ERR_W-1:0] WRAP_LIMIT  = 16'sd19200;
    localparam logic signed [ERR_W-1:0] FULL_TURN   = 16'sd23040;
    localparam logic signed [ERR_W-1:0] BAND_WIDE   = 16'sd320;
    localparam logic signed [ERR_W-1:0] BAND_NARROW = 16'sd96;

    // Wheel speeds of the error bands.
    localparam logic [SPEED_W-1:0] SPD_FAST_L     = 8'd131;
    localparam logic [SPEED_W-1:0] SPD_FAST_R     = 8'd132;
    localparam logic [SPEED_W-1:0] SPD_SLOW_L     = 8'd85;
    localparam logic [SPEED_W-1:0] SPD_BASE_L     = 8'd86;
    localparam logic [SPEED_W-1:0] SPD_BASE_R     = 8'd82;
    localparam logic [SPEED_W-1:0] SPD_NEAR_R     = 8'd96;
    localparam logic [SPEED_W-1:0] SPD_NEAR_L     = 8'd102;
    localparam logic [SPEED_W-1:0] SPD_LIN_R_BASE = 8'd87;
    localparam logic [SPEED_W-1:0] SPD_LIN_L_BASE = 8'd93;

    localparam logic [PULSE_W-1:0] NEUTRAL_PULSE = 11'd1500;

    // Classified item handed from the front end to the back end.
    typedef struct packed {
        logic                    is_start;
        logic [COUNT_W-1:0]      left_delta;
        logic [COUNT_W-1:0]      right_delta;
        logic signed [ERR_W-1:0] err;
    } hhd_cmd_t;

endpackage

`default_nettype wire

/* rtl/hhd_if.sv */
// Handshake channels of the heading-hold drive controller.
`default_nettype none

interface hhd_meas_if;
    import hhd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [HEADING_W-1:0] heading;
    logic [COUNT_W-1:0]   left_count;
    logic [COUNT_W-1:0]   right_count;

    modport source (
        output valid, mode, heading, left_count, right_count,
        input  ready
    );
    modport sink (
        input  valid, mode, heading, left_count, right_count,
        output ready
    );
endinterface

interface hhd_cmd_if;
    import hhd_pkg::*;

    logic               valid;
    logic               ready;
    logic [PULSE_W-1:0] left_pulse;
    logic [PULSE_W-1:0] right_pulse;
    logic               finished;
    logic               last;

    modport source (
        output valid, left_pulse, right_pulse, finished, last,
        input  ready
    );
    modport sink (
        input  valid, left_pulse, right_pulse, finished, last,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/hhd_front.sv */
// Front end: accepts measurements, holds the start references, classifies items.
`default_nettype none

module hhd_front (
    input  wire logic      clk,
    input  wire logic      rst_n,
    hhd_meas_if.sink       meas,
    input  wire logic      q_full,
    output logic           push,
    output hhd_pkg::hhd_cmd_t push_data
);
    import hhd_pkg::*;

    logic                    started_reg;
    logic                    started_next;
    logic [HEADING_W-1:0]    start_heading_reg;
    logic [COUNT_W-1:0]      left_base_reg;
    logic [COUNT_W-1:0]      right_base_reg;
    logic                    accept;
    logic                    is_start;
    logic signed [ERR_W-1:0] diff;
    logic signed [ERR_W-1:0] err;

    // The front end is ready whenever the queue has room.
    assign meas.ready = !q_full;
    assign accept     = meas.valid && meas.ready;
    assign is_start   = (meas.mode == MODE_START);

    // Samples before the first start are dropped here; later stops are resolved
    // in the back end, which sees the items in order.
    assign push = accept && (is_start || started_reg);

    // Heading error against the start heading, wrapped into +-300 degrees.
    always_comb
    begin
        diff = $signed({1'b0, meas.heading}) - $signed({1'b0, start_heading_reg});
        err  = diff;
        if (err > WRAP_LIMIT)
        begin
            err = err - FULL_TURN;
        end
        if (err < -WRAP_LIMIT)
        begin
            err = err + FULL_TURN;
        end
    end

    always_comb
    begin
        push_data.is_start    = is_start;
        push_data.left_delta  = meas.left_count - left_base_reg;
        push_data.right_delta = meas.right_count - right_base_reg;
        push_data.err         = err;
    end

    assign started_next = started_reg || (accept && is_start);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
        end
        else
        begin
            started_reg <= started_next;
        end
    end

    // Reference capture on a start item.
    always_ff @(posedge clk)
    begin
        if (accept && is_start)
        begin
            start_heading_reg <= meas.heading;
            left_base_reg     <= meas.left_count;
            right_base_reg    <= meas.right_count;
        end
    end

endmodule

`default_nettype wire

/* rtl/hhd_queue.sv */
// Short queue between the front end and the back end.
`default_nettype none

module hhd_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire hhd_pkg::hhd_cmd_t push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   pop_valid,
    output hhd_pkg::hhd_cmd_t      pop_data
);
    import hhd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    hhd_cmd_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == FULL_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue fill count beyond depth");
`endif

endmodule

`default_nettype wire

/* rtl/hhd_back.sv */
// Back end: distance products, stop test, speed bands and the result register.
`default_nettype none

module hhd_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire hhd_pkg::hhd_cmd_t             q_data,
    output logic                               pop,
    input  wire logic [hhd_pkg::CIRC_W-1:0]    left_circ,
    input  wire logic [hhd_pkg::CIRC_W-1:0]    right_circ,
    input  wire logic [hhd_pkg::TARGET_W-1:0]  target,
    hhd_cmd_if.source                          cmd
);
    import hhd_pkg::*;

    // Multiply stage.
    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic                    m_start_reg;
    logic [PROD_W-1:0]       m_lprod_reg;
    logic [PROD_W-1:0]       m_rprod_reg;
    logic signed [ERR_W-1:0] m_err_reg;

    // Run state and result register.
    logic               stopped_reg;
    logic               stopped_next;
    logic               stop_pend_reg;
    logic               stop_pend_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [PULSE_W-1:0] out_left_reg;
    logic [PULSE_W-1:0] out_left_next;
    logic [PULSE_W-1:0] out_right_reg;
    logic [PULSE_W-1:0] out_right_next;
    logic               out_finished_reg;
    logic               out_finished_next;
    logic               out_last_reg;
    logic               out_last_next;

    logic                    slot_free;
    logic                    m_consume;
    logic                    m_load;
    logic                    emit_drive;
    logic                    done;
    logic [TRAVEL_W-1:0]     travel;
    logic [TRAVEL_W-1:0]     limit;
    logic signed [ERR_W-1:0] mag;
    logic [11:0]             scaled;
    logic [5:0]              lin;
    logic [SPEED_W-1:0]      left_wheel_spd;
    logic [SPEED_W-1:0]      right_wheel_spd;

    // Handshake between the multiply stage and the result register.
    assign slot_free  = (!out_valid_reg || cmd.ready) && !stop_pend_reg;
    assign m_consume  = m_valid_reg && (m_start_reg || stopped_reg || slot_free);
    assign emit_drive = m_valid_reg && !m_start_reg && !stopped_reg && slot_free;
    assign m_load     = !m_valid_reg || m_consume;
    assign pop        = q_valid && m_load;
    assign m_valid_next = m_load ? q_valid : m_valid_reg;

    // Stop test: twice the distance times 64 against the target times 128.
    assign travel = {1'b0, m_lprod_reg} + {1'b0, m_rprod_reg};
    assign limit  = {target, 7'b0};
    assign done   = (travel >= limit);

    // Linear part of the two proportional bands.
    always_comb
    begin
        mag    = m_err_reg[ERR_W-1] ? -m_err_reg : m_err_reg;
        scaled = {3'b0, mag[8:0]} * 12'd7;
        lin    = scaled[11:6];
    end

    // Error bands to wheel speeds.
    always_comb
    begin
        if (m_err_reg >= BAND_WIDE)
        begin
            left_wheel_spd  = SPD_FAST_L;
            right_wheel_spd = SPD_BASE_R;
        end
        else if (m_err_reg <= -BAND_WIDE)
        begin
            left_wheel_spd  = SPD_SLOW_L;
            right_wheel_spd = SPD_FAST_R;
        end
        else if (m_err_reg >= -BAND_NARROW && m_err_reg <= 16'sd0)
        begin
            left_wheel_spd  = SPD_BASE_L;
            right_wheel_spd = SPD_NEAR_R;
        end
        else if (m_err_reg > 16'sd0 && m_err_reg <= BAND_NARROW)
        begin
            left_wheel_spd  = SPD_NEAR_L;
            right_wheel_spd = SPD_BASE_R;
        end
        else if (m_err_reg < -BAND_NARROW)
        begin
            left_wheel_spd  = SPD_BASE_L;
            right_wheel_spd = SPD_LIN_R_BASE + {2'b0, lin};
        end
        else
        begin
            left_wheel_spd  = SPD_LIN_L_BASE + {2'b0, lin};
            right_wheel_spd = SPD_BASE_R;
        end
    end

    // Result register: a drive result, then the stop result when one is pending.
    always_comb
    begin
        out_valid_next    = out_valid_reg;
        out_left_next     = out_left_reg;
        out_right_next    = out_right_reg;
        out_finished_next = out_finished_reg;
        out_last_next     = out_last_reg;
        stop_pend_next    = stop_pend_reg;
        stopped_next      = stopped_reg;
        if (emit_drive)
        begin
            out_valid_next    = 1'b1;
            out_left_next     = NEUTRAL_PULSE + {3'b0, left_wheel_spd};
            out_right_next    = NEUTRAL_PULSE - {3'b0, right_wheel_spd};
            out_finished_next = 1'b0;
            out_last_next     = !done;
            stop_pend_next    = done;
            stopped_next      = done;
        end
        else if (stop_pend_reg && cmd.ready)
        begin
            out_valid_next    = 1'b1;
            out_left_next     = NEUTRAL_PULSE;
            out_right_next    = NEUTRAL_PULSE;
            out_finished_next = 1'b1;
            out_last_next     = 1'b1;
            stop_pend_next    = 1'b0;
        end
        else if (cmd.ready)
        begin
            out_valid_next = 1'b0;
        end
        // A start item in the stream re-arms the move.
        if (m_valid_reg && m_start_reg)
        begin
            stopped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            stopped_reg   <= 1'b0;
            stop_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg   <= m_valid_next;
            stopped_reg   <= stopped_next;
            stop_pend_reg <= stop_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Multiply stage payload: wheel travel products.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            m_start_reg <= q_data.is_start;
            m_lprod_reg <= {{COUNT_W{1'b0}}, left_circ} * {{CIRC_W{1'b0}}, q_data.left_delta};
            m_rprod_reg <= {{COUNT_W{1'b0}}, right_circ} * {{CIRC_W{1'b0}}, q_data.right_delta};
            m_err_reg   <= q_data.err;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        out_left_reg     <= out_left_next;
        out_right_reg    <= out_right_next;
        out_finished_reg <= out_finished_next;
        out_last_reg     <= out_last_next;
    end

    assign cmd.valid       = out_valid_reg;
    assign cmd.left_pulse  = out_left_reg;
    assign cmd.right_pulse = out_right_reg;
    assign cmd.finished    = out_finished_reg;
    assign cmd.last        = out_last_reg;

`ifndef ASSERT_OFF
    a_pend_behind_drive: assert property (@(posedge clk) disable iff (!rst_n)
        stop_pend_reg |-> (out_valid_reg && !out_last_reg && !out_finished_reg))
        else $error("stop pending without a non-final drive result in the register");
    a_pend_stops_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(stop_pend_reg) |-> stopped_reg)
        else $error("stop scheduled while the move still runs");
    a_finish_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_finished_reg) |->
            (out_last_reg && !stop_pend_reg && out_left_reg == NEUTRAL_PULSE
             && out_right_reg == NEUTRAL_PULSE))
        else $error("final result is not a neutral stop");
`endif

endmodule

`default_nettype wire

/* rtl/heading_hold_drive_controller_top.sv */
// Top level of the heading-hold drive controller with its configuration registers.
//
// Usage:
//   meas carries measurement items (mode, heading, left_count, right_count);
//   a mode 0 item captures the start references and gives no result, a mode 1
//   item while a move runs gives one drive result, or a drive result followed
//   by a neutral stop result once the target distance is reached.
//   cmd carries results (left_pulse, right_pulse, finished, last).
//   Registers are written through cfg_we / cfg_addr / cfg_wdata while idle.
// Timing:
//   One measurement can transfer in every cycle while the queue has room.
//   A result passes from its measurement through the queue entry and the
//   multiply stage into the result register. A stop result is loaded as its
//   drive result transfers and is valid in the cycle after.
//   The QUEUE_DEPTH-entry queue decouples the front end from the back end;
//   meas.ready drops only when the queue is full.
// Reset: the move is idle, the queue and the result register are empty and the
//   registers take their reset values; samples are dropped until a start item.
// Stall: while cmd.ready is low the result holds and the queue fills.
`default_nettype none

module heading_hold_drive_controller_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    hhd_meas_if.sink                             meas,
    hhd_cmd_if.source                            cmd,
    input  wire logic                            cfg_we,
    input  wire logic [hhd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [hhd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import hhd_pkg::*;

    logic [CIRC_W-1:0]   left_circ_reg;
    logic [CIRC_W-1:0]   right_circ_reg;
    logic [TARGET_W-1:0] target_reg;

    logic     push;
    hhd_cmd_t push_data;
    logic     q_full;
    logic     pop;
    logic     q_valid;
    hhd_cmd_t q_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_circ_reg  <= CIRC_RESET;
            right_circ_reg <= CIRC_RESET;
            target_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_LEFT_CIRC:  left_circ_reg  <= cfg_wdata[CIRC_W-1:0];
                CFG_RIGHT_CIRC: right_circ_reg <= cfg_wdata[CIRC_W-1:0];
                CFG_TARGET:     target_reg     <= cfg_wdata[TARGET_W-1:0];
                default:        ;
            endcase
        end
    end

    hhd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .meas      (meas),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    hhd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    hhd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .pop        (pop),
        .left_circ  (left_circ_reg),
        .right_circ (right_circ_reg),
        .target     (target_reg),
        .cmd        (cmd)
    );

endmodule

`default_nettype wire
